FILE: rtl/core/cara_pkg.sv
// shared types, request codes and flag positions of the arithmetic register alu
package cara_pkg;

    // request codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_ADC  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_INR  = 4'd3;
    localparam logic [3:0] OP_DCR  = 4'd4;
    localparam logic [3:0] OP_INX  = 4'd5;
    localparam logic [3:0] OP_DCX  = 4'd6;
    localparam logic [3:0] OP_DAD  = 4'd7;
    localparam logic [3:0] OP_LOAD = 4'd8;

    // register indexes and pair rows
    localparam int unsigned NUM_REGS = 7;
    localparam logic [2:0] REG_A    = 3'd0;
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam logic [1:0] ROW_HL   = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    // flag bit positions
    localparam int unsigned FLG_S  = 0;
    localparam int unsigned FLG_Z  = 1;
    localparam int unsigned FLG_AC = 2;
    localparam int unsigned FLG_P  = 3;
    localparam int unsigned FLG_CY = 4;
    localparam int unsigned NUM_FLAGS = 5;

    typedef struct packed {
        logic [3:0] req_type;
        logic [2:0] reg_sel;
        logic       use_imm;
        logic [7:0] imm_data;
    } t_req;

    typedef struct packed {
        logic [15:0]          dest_value;
        logic [7:0]           acc_value;
        logic [NUM_FLAGS-1:0] flags;
        logic [15:0]          prog_counter;
    } t_rsp;

    // what the state block shows the alu
    typedef struct packed {
        logic [7:0]           acc;
        logic [15:0]          hl;
        logic [15:0]          row_word;
        logic [NUM_FLAGS-1:0] flags;
        logic [15:0]          pc;
    } t_state;

    // state update produced by the alu
    typedef struct packed {
        logic                 byte_en;
        logic [2:0]           idx;
        logic                 pair_en;
        logic [1:0]           row;
        logic [15:0]          data;
        logic [NUM_FLAGS-1:0] flags;
        logic [15:0]          pc;
    } t_wr;

endpackage

FILE: rtl/core/cara_if.sv
// valid/ready channel interfaces for requests and responses

interface cara_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] req_type;
    logic [2:0] reg_sel;
    logic       use_imm;
    logic [7:0] imm_data;

    modport source (output valid, output req_type, output reg_sel, output use_imm,
                    output imm_data, input ready);
    modport sink   (input valid, input req_type, input reg_sel, input use_imm,
                    input imm_data, output ready);
endinterface

interface cara_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] dest_value;
    logic [7:0]  acc_value;
    logic        sign_flag;
    logic        zero_flag;
    logic        aux_flag;
    logic        parity_flag;
    logic        carry_flag;
    logic [15:0] prog_counter;

    modport source (output valid, output dest_value, output acc_value, output sign_flag,
                    output zero_flag, output aux_flag, output parity_flag,
                    output carry_flag, output prog_counter, input ready);
    modport sink   (input valid, input dest_value, input acc_value, input sign_flag,
                    input zero_flag, input aux_flag, input parity_flag,
                    input carry_flag, input prog_counter, output ready);
endinterface

FILE: rtl/core/cara_state.sv
// register file, flags and program counter with one row read port
module cara_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_rd_row,
    input  logic              i_wr_en,
    input  cara_pkg::t_wr     i_wr,
    output cara_pkg::t_state  o_state
);

    logic [7:0]                     r_regs [cara_pkg::NUM_REGS];
    logic [cara_pkg::NUM_FLAGS-1:0] r_flags;
    logic [15:0]                    r_pc;
    logic [2:0]                     rd_hi;
    logic [2:0]                     wr_hi;

    // pair row n holds registers 2n+1 (high) and 2n+2 (low)
    assign rd_hi = {i_rd_row, 1'b1};
    assign wr_hi = {i_wr.row, 1'b1};

    always_comb begin
        o_state.acc   = r_regs[cara_pkg::REG_A];
        o_state.hl    = {r_regs[3'd5], r_regs[3'd6]};
        o_state.flags = r_flags;
        o_state.pc    = r_pc;
        if (i_rd_row == cara_pkg::ROW_NONE) begin
            o_state.row_word = 16'h0000;
        end else begin
            o_state.row_word = {r_regs[rd_hi], r_regs[rd_hi + 3'd1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cara_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'h00;
            end
            r_flags <= '0;
            r_pc    <= 16'h0000;
        end else if (i_wr_en) begin
            if (i_wr.byte_en && i_wr.idx != cara_pkg::REG_NONE) begin
                r_regs[i_wr.idx] <= i_wr.data[7:0];
            end
            if (i_wr.pair_en && i_wr.row != cara_pkg::ROW_NONE) begin
                r_regs[wr_hi]        <= i_wr.data[15:8];
                r_regs[wr_hi + 3'd1] <= i_wr.data[7:0];
            end
            r_flags <= i_wr.flags;
            r_pc    <= i_wr.pc;
        end
    end

endmodule

FILE: rtl/core/cara_alu.sv
// one-pass execute logic: operand select, 8/16-bit add and subtract, immediate load, flags
module cara_alu (
    input  cara_pkg::t_req    i_req,
    input  cara_pkg::t_state  i_state,
    output logic [1:0]        o_rd_row,
    output cara_pkg::t_wr     o_wr,
    output cara_pkg::t_rsp    o_rsp
);

    logic [2:0]  sel;
    logic        pair_op;
    logic [2:0]  sel_m1;
    logic [7:0]  reg8;
    logic [7:0]  opnd;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [7:0]  res8;
    logic [16:0] sum17;
    logic        pc_two;
    logic        set_szp;

    assign sel     = i_req.reg_sel;
    assign pair_op = (i_req.req_type == cara_pkg::OP_INX) ||
                     (i_req.req_type == cara_pkg::OP_DCX) ||
                     (i_req.req_type == cara_pkg::OP_DAD);
    assign sel_m1  = sel - 3'd1;
    // byte registers 1..6 live in rows 0..2; a and index seven are handled here
    assign o_rd_row = pair_op ? sel[2:1] : sel_m1[2:1];

    always_comb begin
        if (sel == cara_pkg::REG_A) begin
            reg8 = i_state.acc;
        end else if (sel == cara_pkg::REG_NONE) begin
            reg8 = 8'h00;
        end else if (sel[0]) begin
            reg8 = i_state.row_word[15:8];
        end else begin
            reg8 = i_state.row_word[7:0];
        end
    end

    assign opnd  = i_req.use_imm ? i_req.imm_data : reg8;
    assign cin   = (i_req.req_type == cara_pkg::OP_ADC) && i_state.flags[cara_pkg::FLG_CY];
    assign sum9  = {1'b0, i_state.acc} + {1'b0, opnd} + {8'h00, cin};
    assign sum5  = {1'b0, i_state.acc[3:0]} + {1'b0, opnd[3:0]} + {4'h0, cin};
    assign sum17 = {1'b0, i_state.hl} + {1'b0, i_state.row_word};

    always_comb begin
        o_wr.byte_en = 1'b0;
        o_wr.idx     = sel;
        o_wr.pair_en = 1'b0;
        o_wr.row     = o_rd_row;
        o_wr.data    = 16'h0000;
        o_wr.flags   = i_state.flags;
        pc_two       = 1'b0;
        set_szp      = 1'b0;
        res8         = 8'h00;
        case (i_req.req_type)
            cara_pkg::OP_ADD, cara_pkg::OP_ADC: begin
                res8         = sum9[7:0];
                o_wr.byte_en = 1'b1;
                o_wr.idx     = cara_pkg::REG_A;
                o_wr.flags[cara_pkg::FLG_AC] = sum5[4];
                o_wr.flags[cara_pkg::FLG_CY] = sum9[8];
                set_szp      = 1'b1;
                pc_two       = i_req.use_imm;
            end
            cara_pkg::OP_SUB: begin
                res8         = i_state.acc - opnd;
                o_wr.byte_en = 1'b1;
                o_wr.idx     = cara_pkg::REG_A;
                o_wr.flags[cara_pkg::FLG_AC] = i_state.acc[3:0] < opnd[3:0];
                o_wr.flags[cara_pkg::FLG_CY] = i_state.acc < opnd;
                set_szp      = 1'b1;
                pc_two       = i_req.use_imm;
            end
            cara_pkg::OP_INR: begin
                res8         = reg8 + 8'd1;
                o_wr.byte_en = 1'b1;
                o_wr.flags[cara_pkg::FLG_AC] = reg8[3:0] == 4'hF;
                set_szp      = 1'b1;
            end
            cara_pkg::OP_DCR: begin
                res8         = reg8 - 8'd1;
                o_wr.byte_en = 1'b1;
                o_wr.flags[cara_pkg::FLG_AC] = reg8[3:0] != 4'h0;
                set_szp      = 1'b1;
            end
            cara_pkg::OP_INX: begin
                o_wr.pair_en = 1'b1;
                o_wr.data    = i_state.row_word + 16'd1;
            end
            cara_pkg::OP_DCX: begin
                o_wr.pair_en = 1'b1;
                o_wr.data    = i_state.row_word - 16'd1;
            end
            cara_pkg::OP_DAD: begin
                o_wr.pair_en = 1'b1;
                o_wr.row     = cara_pkg::ROW_HL;
                o_wr.data    = sum17[15:0];
                o_wr.flags[cara_pkg::FLG_CY] = sum17[16];
            end
            cara_pkg::OP_LOAD: begin
                res8         = i_req.imm_data;
                o_wr.byte_en = 1'b1;
                pc_two       = 1'b1;
            end
            default: begin
            end
        endcase
        if (o_wr.byte_en) begin
            o_wr.data = {8'h00, res8};
        end
        if (set_szp) begin
            o_wr.flags[cara_pkg::FLG_S] = res8[7];
            o_wr.flags[cara_pkg::FLG_Z] = res8 == 8'h00;
            o_wr.flags[cara_pkg::FLG_P] = ~^res8;
        end
        // unknown requests leave the program counter alone
        if (i_req.req_type > cara_pkg::OP_LOAD) begin
            o_wr.pc = i_state.pc;
        end else begin
            o_wr.pc = i_state.pc + (pc_two ? 16'd2 : 16'd1);
        end
    end

    always_comb begin
        o_rsp.dest_value   = o_wr.data;
        o_rsp.flags        = o_wr.flags;
        o_rsp.prog_counter = o_wr.pc;
        if (o_wr.byte_en && o_wr.idx == cara_pkg::REG_A) begin
            o_rsp.acc_value = res8;
        end else begin
            o_rsp.acc_value = i_state.acc;
        end
    end

endmodule

FILE: rtl/core/cpu_arith_register_alu_core.sv
// top level of the arithmetic register alu: input register, execute, result register
//
//  channel  | dir | fields                                             | handshake
//  ---------+-----+----------------------------------------------------+-------------
//  i_req    | in  | req_type, reg_sel, use_imm, imm_data               | valid/ready
//  o_rsp    | out | dest_value, acc_value, five flags, prog_counter    | valid/ready
//
//  one item per cycle sustained while o_rsp.ready holds; an item waits in the input register
//  and is executed against the register file on its way into the result register,
//  so its result goes on o_rsp when the result register, once free, takes it
//  the register file, flags and pc update in the same edge that loads the result
//  register, so the next item always sees the previous one's state
//  i_rst_n (synchronous) clears the register file, flags, pc and both valid bits
//  a stalled o_rsp holds its item; the input register still takes one more item
//  before i_req.ready drops
module cpu_arith_register_alu_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cara_req_if.sink   i_req,
    cara_rsp_if.source o_rsp
);

    // input stage
    logic             r_in_valid;
    cara_pkg::t_req   r_in;
    // result stage
    logic             r_out_valid;
    cara_pkg::t_rsp   r_out;

    logic             in_fire;
    logic             advance;
    logic [1:0]       rd_row;
    cara_pkg::t_state state;
    cara_pkg::t_wr    wr;
    cara_pkg::t_rsp   n_out;

    // execute moves the input register on whenever the result register frees up
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_fire     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.req_type <= i_req.req_type;
            r_in.reg_sel  <= i_req.reg_sel;
            r_in.use_imm  <= i_req.use_imm;
            r_in.imm_data <= i_req.imm_data;
        end
    end

    cara_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_row (rd_row),
        .i_wr_en  (advance),
        .i_wr     (wr),
        .o_state  (state)
    );

    cara_alu u_alu (
        .i_req    (r_in),
        .i_state  (state),
        .o_rd_row (rd_row),
        .o_wr     (wr),
        .o_rsp    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // result port
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.dest_value   = r_out.dest_value;
    assign o_rsp.acc_value    = r_out.acc_value;
    assign o_rsp.sign_flag    = r_out.flags[cara_pkg::FLG_S];
    assign o_rsp.zero_flag    = r_out.flags[cara_pkg::FLG_Z];
    assign o_rsp.aux_flag     = r_out.flags[cara_pkg::FLG_AC];
    assign o_rsp.parity_flag  = r_out.flags[cara_pkg::FLG_P];
    assign o_rsp.carry_flag   = r_out.flags[cara_pkg::FLG_CY];
    assign o_rsp.prog_counter = r_out.prog_counter;

endmodule

FILE: rtl/core/cara_chk.sv
// port-level checker for the arithmetic register alu, bound to the top level
module cara_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_dest_value,
    input logic [7:0]  i_acc_value,
    input logic [15:0] i_prog_counter
);

    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        r_seen;
    logic [15:0] r_last_pc;
    logic [15:0] pc_step;
    logic        in_fire;
    logic        out_fire;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;
    assign n_cnt    = r_cnt + {1'b0, in_fire} - {1'b0, out_fire};
    assign pc_step  = i_prog_counter - r_last_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_seen <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (out_fire) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_last_pc <= i_prog_counter;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_dest_value) && $stable(i_acc_value) && $stable(i_prog_counter))
        else $error("result changed while stalled");

    // never more than two items in flight, and no result without an item
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && (!i_out_valid || r_cnt != 2'd0))
        else $error("items in flight out of range");

    // input back-pressure only comes from a stalled result
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // pc moves by 0, 1 or 2 between successive results
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_seen |-> (pc_step == 16'd0 || pc_step == 16'd1 || pc_step == 16'd2))
        else $error("program counter jumped");

    // no result right out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind cpu_arith_register_alu_core cara_chk u_cara_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_dest_value   (o_rsp.dest_value),
    .i_acc_value    (o_rsp.acc_value),
    .i_prog_counter (o_rsp.prog_counter)
);
